/* hdl/hcp_pkg.sv */
// Shared types, codes and helper function of the HTTP chunk header parser.
package hcp_pkg;

    localparam int SIZE_BITS_DEFAULT = 64;
    localparam int CHUNK_SIZE_BITS   = 64;
    localparam int LIMIT_BITS        = 16;
    localparam int APB_ADDR_BITS     = 3;
    localparam int APB_DATA_BITS     = 32;

    localparam logic [LIMIT_BITS-1:0] HEADER_LIMIT_RESET  = 16'd64;
    localparam logic [LIMIT_BITS-1:0] TRAILER_LIMIT_RESET = 16'd8192;

    localparam logic REG_HEADER_LIMIT  = 1'b0;
    localparam logic REG_TRAILER_LIMIT = 1'b1;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    localparam logic [1:0] KIND_SIZE  = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [2:0] ERR_EMPTY        = 3'd0;
    localparam logic [2:0] ERR_NO_HEX       = 3'd1;
    localparam logic [2:0] ERR_OVERFLOW     = 3'd2;
    localparam logic [2:0] ERR_HEADER_LONG  = 3'd3;
    localparam logic [2:0] ERR_MISSING_CRLF = 3'd4;
    localparam logic [2:0] ERR_TRAILER_LONG = 3'd5;

    localparam logic [1:0] PEND_NONE     = 2'd0;
    localparam logic [1:0] PEND_NO_HEX   = 2'd2;
    localparam logic [1:0] PEND_OVERFLOW = 2'd3;

    typedef struct packed {
        logic [LIMIT_BITS-1:0] header_limit;
        logic [LIMIT_BITS-1:0] trailer_limit;
    } cfg_t;

    typedef struct packed {
        logic [1:0]                 kind;
        logic [CHUNK_SIZE_BITS-1:0] size;
        logic [2:0]                 code;
    } result_t;

    // Returns the digit value in the low four bits and a valid flag on top.
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            r = {1'b1, b[3:0]};
        end
        else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
        begin
            r = {1'b1, b[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

/* hdl/hcp_stream_if.sv */
// Stream interfaces for framing bytes in and parse results out.
interface hcp_byte_if
    import hcp_pkg::*;
    ();
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface hcp_result_if
    import hcp_pkg::*;
    ();
    logic                       valid;
    logic                       ready;
    logic [1:0]                 result_kind;
    logic [CHUNK_SIZE_BITS-1:0] chunk_size;
    logic [2:0]                 error_code;

    modport source (output valid, output result_kind, output chunk_size, output error_code,
                    input ready);
    modport sink (input valid, input result_kind, input chunk_size, input error_code,
                  output ready);
endinterface

/* hdl/hcp_cfg_regs.sv */
// APB register block holding the header and trailer byte limits.
module hcp_cfg_regs
    import hcp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output cfg_t                     cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_limit  <= HEADER_LIMIT_RESET;
            cfg_reg.trailer_limit <= TRAILER_LIMIT_RESET;
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_HEADER_LIMIT)
            begin
                cfg_reg.header_limit <= pwdata[LIMIT_BITS-1:0];
            end
            else
            begin
                cfg_reg.trailer_limit <= pwdata[LIMIT_BITS-1:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_HEADER_LIMIT)
        begin
            prdata = APB_DATA_BITS'(cfg_reg.header_limit);
        end
        else
        begin
            prdata = APB_DATA_BITS'(cfg_reg.trailer_limit);
        end
    end

endmodule

/* hdl/hcp_engine.sv */
// Parser state machine with its combinational next-state logic and the result register.
module hcp_engine
    import hcp_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       item_valid,
    input  logic [7:0] item_byte,
    input  logic       res_ready,
    output logic       take,
    output logic       res_valid,
    output result_t    res
);

    typedef enum logic [2:0] {
        PH_LINE_START,
        PH_DIGITS,
        PH_REST,
        PH_TERM_CR,
        PH_TERM_LF,
        PH_TRAILERS
    } phase_t;

    phase_t                phase_reg, phase_next;
    logic [SIZE_BITS-1:0]  size_reg, size_next;
    logic [LIMIT_BITS-1:0] count_reg, count_next;
    logic [23:0]           recent_reg, recent_next;
    logic [1:0]            pend_reg, pend_next;
    logic                  res_valid_reg;
    result_t               res_reg;

    logic [LIMIT_BITS-1:0] cnt;
    logic [31:0]           window;
    logic [7:0]            prev;
    logic [4:0]            hex;
    logic                  fire;
    logic                  clear;
    result_t               res_next;

    assign take      = !res_valid_reg || res_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign cnt    = (count_reg != {LIMIT_BITS{1'b1}}) ? count_reg + 1'b1 : count_reg;
    assign window = {recent_reg, item_byte};
    assign prev   = recent_reg[7:0];
    assign hex    = hex_digit(item_byte);

    always_comb
    begin
        phase_next  = phase_reg;
        size_next   = size_reg;
        count_next  = cnt;
        recent_next = recent_reg;
        pend_next   = pend_reg;
        fire        = 1'b0;
        clear       = 1'b0;
        res_next    = '0;

        unique case (phase_reg)
            PH_TRAILERS:
            begin
                if ((cnt == 16'd2 && window[15:0] == {CH_CR, CH_LF}) ||
                    (cnt >= 16'd4 && window == {CH_CR, CH_LF, CH_CR, CH_LF}))
                begin
                    fire          = 1'b1;
                    clear         = 1'b1;
                    res_next.kind = KIND_END;
                end
                else if (cnt >= cfg.trailer_limit)
                begin
                    fire          = 1'b1;
                    clear         = 1'b1;
                    res_next.kind = KIND_ERROR;
                    res_next.code = ERR_TRAILER_LONG;
                end
                else
                begin
                    recent_next = window[23:0];
                end
            end
            PH_TERM_CR:
            begin
                recent_next = {16'd0, item_byte};
                phase_next  = PH_TERM_LF;
                if (cnt >= cfg.header_limit)
                begin
                    fire          = 1'b1;
                    clear         = 1'b1;
                    res_next.kind = KIND_ERROR;
                    res_next.code = ERR_HEADER_LONG;
                end
            end
            PH_TERM_LF:
            begin
                if (prev != CH_CR || item_byte != CH_LF)
                begin
                    fire          = 1'b1;
                    clear         = 1'b1;
                    res_next.kind = KIND_ERROR;
                    res_next.code = ERR_MISSING_CRLF;
                end
                else
                begin
                    recent_next = '0;
                    phase_next  = PH_LINE_START;
                    if (cnt >= cfg.header_limit)
                    begin
                        fire          = 1'b1;
                        clear         = 1'b1;
                        res_next.kind = KIND_ERROR;
                        res_next.code = ERR_HEADER_LONG;
                    end
                end
            end
            PH_LINE_START, PH_DIGITS, PH_REST:
            begin
                if (prev == CH_CR && item_byte == CH_LF)
                begin
                    if (phase_reg == PH_LINE_START)
                    begin
                        fire          = 1'b1;
                        clear         = 1'b1;
                        res_next.kind = KIND_ERROR;
                        res_next.code = ERR_EMPTY;
                    end
                    else if (pend_reg != PEND_NONE)
                    begin
                        fire          = 1'b1;
                        clear         = 1'b1;
                        res_next.kind = KIND_ERROR;
                        res_next.code = (pend_reg == PEND_NO_HEX) ? ERR_NO_HEX : ERR_OVERFLOW;
                    end
                    else
                    begin
                        size_next   = '0;
                        count_next  = '0;
                        recent_next = '0;
                        pend_next   = PEND_NONE;
                        if (size_reg != '0)
                        begin
                            phase_next    = PH_TERM_CR;
                            fire          = 1'b1;
                            res_next.kind = KIND_SIZE;
                            res_next.size = CHUNK_SIZE_BITS'(size_reg);
                        end
                        else
                        begin
                            phase_next = PH_TRAILERS;
                        end
                    end
                end
                else
                begin
                    // A CR that is not followed by LF counts as a non-hex byte.
                    if (prev == CH_CR)
                    begin
                        if (phase_reg == PH_LINE_START)
                        begin
                            pend_next  = PEND_NO_HEX;
                            phase_next = PH_REST;
                        end
                        else if (phase_reg == PH_DIGITS)
                        begin
                            phase_next = PH_REST;
                        end
                    end
                    else if (item_byte != CH_CR)
                    begin
                        if (phase_reg == PH_LINE_START)
                        begin
                            if (hex[4])
                            begin
                                size_next  = SIZE_BITS'(hex[3:0]);
                                phase_next = PH_DIGITS;
                            end
                            else
                            begin
                                pend_next  = PEND_NO_HEX;
                                phase_next = PH_REST;
                            end
                        end
                        else if (phase_reg == PH_DIGITS)
                        begin
                            if (!hex[4])
                            begin
                                phase_next = PH_REST;
                            end
                            else if (size_reg[SIZE_BITS-1 -: 4] != 4'd0)
                            begin
                                pend_next  = PEND_OVERFLOW;
                                phase_next = PH_REST;
                            end
                            else
                            begin
                                size_next = {size_reg[SIZE_BITS-5:0], hex[3:0]};
                            end
                        end
                    end
                    recent_next = {16'd0, item_byte};
                    if (cnt >= cfg.header_limit)
                    begin
                        fire          = 1'b1;
                        clear         = 1'b1;
                        res_next.kind = KIND_ERROR;
                        res_next.code = ERR_HEADER_LONG;
                    end
                end
            end
            default:
            begin
                clear = 1'b1;
            end
        endcase

        if (clear)
        begin
            phase_next  = PH_LINE_START;
            size_next   = '0;
            count_next  = '0;
            recent_next = '0;
            pend_next   = PEND_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LINE_START;
            size_reg      <= '0;
            count_reg     <= '0;
            recent_reg    <= '0;
            pend_reg      <= PEND_NONE;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else if (take)
        begin
            res_valid_reg <= item_valid && fire;
            res_reg       <= res_next;
            if (item_valid)
            begin
                phase_reg  <= phase_next;
                size_reg   <= size_next;
                count_reg  <= count_next;
                recent_reg <= recent_next;
                pend_reg   <= pend_next;
            end
        end
    end

endmodule

/* hdl/http_chunk_header_parser_unit.sv */
// Top level of the HTTP chunked-body header parser.
// Framing bytes of a chunked HTTP body enter on byte_ch, one per transfer, and the
// block accepts a byte in every clock cycle while results are being taken; each byte
// passes an input register, the parser state update and a result register, so a
// result can be transferred once its byte has passed both registers, and the sustained
// rate of one byte per cycle is set by that state update. A result carries a chunk size,
// end of body, or an error code; after end of body or an error the parser is back at the
// start of a body. The header and trailer limits are written over the APB port at
// addresses 0 and 4, by the user only while no byte is in flight; the block does not enforce it.
module http_chunk_header_parser_unit
    import hcp_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    hcp_byte_if.sink                 byte_ch,
    hcp_result_if.source             result_ch
);

    cfg_t       cfg;
    logic       byte_valid_reg;
    logic [7:0] byte_reg;
    logic       take;
    logic       res_valid;
    result_t    res;

    hcp_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign byte_ch.ready = !byte_valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
            byte_reg       <= '0;
        end
        else if (byte_ch.ready)
        begin
            byte_valid_reg <= byte_ch.valid;
            if (byte_ch.valid)
            begin
                byte_reg <= byte_ch.data_byte;
            end
        end
    end

    hcp_engine #(
        .SIZE_BITS (SIZE_BITS)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (byte_valid_reg),
        .item_byte  (byte_reg),
        .res_ready  (result_ch.ready),
        .take       (take),
        .res_valid  (res_valid),
        .res        (res)
    );

    assign result_ch.valid       = res_valid;
    assign result_ch.result_kind = res.kind;
    assign result_ch.chunk_size  = res.size;
    assign result_ch.error_code  = res.code;

    // A reported chunk size is never zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_ch.valid && result_ch.result_kind == KIND_SIZE |-> result_ch.chunk_size != '0)
    else $error("chunk size result with zero size");

    // End of body and error results carry no size; only errors carry a code.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_ch.valid && result_ch.result_kind != KIND_SIZE
        |-> result_ch.chunk_size == '0 &&
            (result_ch.result_kind == KIND_ERROR || result_ch.error_code == ERR_EMPTY))
    else $error("result fields inconsistent with result kind");

    // A held byte is not overwritten while the result register is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid_reg && result_ch.valid && !result_ch.ready |-> !byte_ch.ready)
    else $error("input register accepts a byte while stalled");

    // The size never exceeds the accumulator width.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_ch.valid |-> (result_ch.chunk_size >> SIZE_BITS) == '0)
    else $error("chunk size wider than the accumulator");

endmodule
